@@ rtl/core/sks_pkg.sv @@
// shared constants and types for the scalar kalman smoother
// used by the channel interfaces, the divider, the multiplier and the top level
package sks_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int FRAC_W     = 16;
    localparam int EST_W      = SAMPLE_W + FRAC_W;
    localparam int ERR_W      = 24;
    localparam int ME_W       = 24;
    localparam int Q_W        = 16;
    localparam int GAIN_W     = FRAC_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = EST_W;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // divider: quotient bits 16 down to 0
    localparam int DIV_Q_W   = GAIN_W + 1;
    localparam int DIV_CNT_W = 5;
    localparam int DEN_W     = ERR_W + 1;
    localparam int REM_W     = ERR_W + 2;

    localparam logic [ME_W-1:0]  ME_RESET  = 24'd131072;
    localparam logic [Q_W-1:0]   Q_RESET   = 16'd66;
    localparam logic [ERR_W-1:0] ERR_RESET = 24'd131072;
    localparam logic [ERR_W-1:0] ERR_MAX   = {ERR_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_MEAS_ERR   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 1'd1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_M1   = 6'b000100,
        S_M2   = 6'b001000,
        S_M3   = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    typedef struct packed {
        logic              done;
        logic [GAIN_W-1:0] gain;
    } div_rsp_t;

endpackage

@@ rtl/core/sks_if.sv @@
// valid/ready channel interfaces for sample requests and filtered results
// depends on sks_pkg for the field widths
interface sks_in_if;
    logic                          valid;
    logic                          ready;
    logic [sks_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface sks_out_if;
    logic                          valid;
    logic                          ready;
    logic [sks_pkg::SAMPLE_W-1:0]  filtered_sample;
    logic [sks_pkg::EST_W-1:0]     filtered_full;

    modport source (output valid, output filtered_sample, output filtered_full, input ready);
    modport sink   (input valid, input filtered_sample, input filtered_full, output ready);
endinterface

@@ rtl/core/sks_div.sv @@
// restoring divider for the gain err * 2^16 / (err + measurement_error)
// one quotient bit per cycle; depends on sks_pkg
module sks_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sks_pkg::ERR_W-1:0]   err,
    input  logic [sks_pkg::ME_W-1:0]    me,
    output sks_pkg::div_rsp_t           rsp
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [sks_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [sks_pkg::REM_W-1:0]       rem_reg;
    logic [sks_pkg::DEN_W-1:0]       den_reg;
    logic [sks_pkg::DIV_Q_W-1:0]     q_reg;

    logic                            ge;
    logic [sks_pkg::REM_W-1:0]       diff;
    logic [sks_pkg::REM_W-1:0]       rem_next;

    always_comb
    begin
        ge       = rem_reg >= {1'b0, den_reg};
        diff     = rem_reg - {1'b0, den_reg};
        rem_next = ge ? {diff[sks_pkg::REM_W-2:0], 1'b0} : {rem_reg[sks_pkg::REM_W-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // quotient is at most 2^16 since err <= den
            rem_reg <= {2'b00, err};
            den_reg <= {1'b0, err} + {1'b0, me};
            cnt_reg <= sks_pkg::DIV_CNT_W'(sks_pkg::DIV_Q_W - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[sks_pkg::DIV_Q_W-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        if (den_reg == '0)
            rsp.gain = '0;
        else if (q_reg[sks_pkg::DIV_Q_W-1])
            rsp.gain = {sks_pkg::GAIN_W{1'b1}};
        else
            rsp.gain = q_reg[sks_pkg::GAIN_W-1:0];
    end

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && cnt_reg != '0 |-> !start)
        else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");
`endif

endmodule

@@ rtl/core/sks_mul.sv @@
// shared unsigned multiplier with a registered product
// depends on sks_pkg for the operand widths
module sks_mul
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [sks_pkg::MUL_A_W-1:0]   a,
    input  logic [sks_pkg::MUL_B_W-1:0]   b,
    output logic [sks_pkg::PROD_W-1:0]    prod
);

    logic [sks_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= {{sks_pkg::MUL_B_W{1'b0}}, a} * {{sks_pkg::MUL_A_W{1'b0}}, b};
    end

    assign prod = prod_reg;

endmodule

@@ rtl/core/scalar_kalman_smoother.sv @@
// scalar kalman smoother top level: sequencer, state and config registers
// depends on sks_pkg, sks_if, sks_div and sks_mul
//
// usage:
//   in_ch carries one 12-bit converter sample per request (valid/ready);
//   out_ch returns one result per sample: filtered_sample, the integer
//   part of the new estimate, and filtered_full, the estimate in Q12.16.
//   cfg_we/cfg_index/cfg_data write measurement_error (index 0, Q8.16)
//   and process_noise (index 1, Q0.16); write only while the block is idle.
//   in_ch.ready returns once the result is loaded into the output register,
//   so a new sample is not taken before the last one is through. the gain
//   comes from the 17-step restoring divider, and the three products after
//   it share one multiplier, one per cycle.
//   reset: estimate 0, error 2.0, measurement_error 2.0, process_noise 66.
//   a stalled receiver holds the result in the output register; the next
//   sample is still taken and runs until it needs that register, then waits.
module scalar_kalman_smoother
(
    input  logic                              clk,
    input  logic                              rst_n,
    sks_in_if.sink                            in_ch,
    sks_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [sks_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sks_pkg::CFG_DATA_W-1:0]    cfg_data
);

    sks_pkg::state_t                  state_reg;
    sks_pkg::state_t                  state_next;

    logic [sks_pkg::ME_W-1:0]         me_reg;
    logic [sks_pkg::Q_W-1:0]          q_reg;
    logic [sks_pkg::EST_W-1:0]        est_reg;
    logic [sks_pkg::ERR_W-1:0]        err_reg;

    logic                             dir_reg;
    logic [sks_pkg::EST_W-1:0]        mag_reg;
    logic [sks_pkg::GAIN_W-1:0]       gain_reg;
    logic [sks_pkg::EST_W-1:0]        step_reg;
    logic [sks_pkg::EST_W-1:0]        next_est_reg;
    logic [sks_pkg::ERR_W-1:0]        e1_reg;

    logic                             out_valid_reg;
    logic [sks_pkg::SAMPLE_W-1:0]     out_sample_reg;
    logic [sks_pkg::EST_W-1:0]        out_full_reg;

    logic                             accept;
    logic                             fire_out;
    logic [sks_pkg::EST_W-1:0]        smp;
    logic                             smp_ge;

    sks_pkg::div_rsp_t                div_rsp;

    logic                             mul_en;
    logic [sks_pkg::MUL_A_W-1:0]      mul_a;
    logic [sks_pkg::MUL_B_W-1:0]      mul_b;
    logic [sks_pkg::PROD_W-1:0]       prod;
    logic [sks_pkg::EST_W-1:0]        prod_hi;

    logic [sks_pkg::EST_W:0]          err_sum;
    logic [sks_pkg::ERR_W-1:0]        err_new;

    assign accept   = in_ch.valid && in_ch.ready;
    assign fire_out = (state_reg == sks_pkg::S_FIN) && (!out_valid_reg || out_ch.ready);
    assign smp      = {in_ch.sample, {sks_pkg::FRAC_W{1'b0}}};
    assign smp_ge   = smp >= est_reg;
    assign prod_hi  = prod[sks_pkg::FRAC_W +: sks_pkg::EST_W];

    assign in_ch.ready            = state_reg == sks_pkg::S_IDLE;
    assign out_ch.valid           = out_valid_reg;
    assign out_ch.filtered_sample = out_sample_reg;
    assign out_ch.filtered_full   = out_full_reg;

    sks_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .err   (err_reg),
        .me    (me_reg),
        .rsp   (div_rsp)
    );

    sks_mul u_mul
    (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            sks_pkg::S_M1:
            begin
                mul_en = 1'b1;
                mul_a  = mag_reg;
                mul_b  = {1'b0, gain_reg};
            end
            sks_pkg::S_M2:
            begin
                // (1 - gain) * err
                mul_en = 1'b1;
                mul_a  = {{(sks_pkg::EST_W - sks_pkg::ERR_W){1'b0}}, err_reg};
                mul_b  = {1'b1, {sks_pkg::GAIN_W{1'b0}}} - {1'b0, gain_reg};
            end
            sks_pkg::S_M3:
            begin
                mul_en = 1'b1;
                mul_a  = step_reg;
                mul_b  = {1'b0, q_reg};
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // new error with saturation
    always_comb
    begin
        err_sum = {{(sks_pkg::EST_W + 1 - sks_pkg::ERR_W){1'b0}}, e1_reg} + {1'b0, prod_hi};
        if (err_sum[sks_pkg::EST_W:sks_pkg::ERR_W] != '0)
            err_new = sks_pkg::ERR_MAX;
        else
            err_new = err_sum[sks_pkg::ERR_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sks_pkg::S_IDLE: if (accept) state_next = sks_pkg::S_DIV;
            sks_pkg::S_DIV:  if (div_rsp.done) state_next = sks_pkg::S_M1;
            sks_pkg::S_M1:   state_next = sks_pkg::S_M2;
            sks_pkg::S_M2:   state_next = sks_pkg::S_M3;
            sks_pkg::S_M3:   state_next = sks_pkg::S_FIN;
            sks_pkg::S_FIN:  if (fire_out) state_next = sks_pkg::S_IDLE;
            default:         state_next = sks_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sks_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            me_reg        <= sks_pkg::ME_RESET;
            q_reg         <= sks_pkg::Q_RESET;
            est_reg       <= '0;
            err_reg       <= sks_pkg::ERR_RESET;
        end
        else
        begin
            state_reg <= state_next;

            if (fire_out)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    sks_pkg::REG_MEAS_ERR:   me_reg <= cfg_data[sks_pkg::ME_W-1:0];
                    sks_pkg::REG_PROC_NOISE: q_reg  <= cfg_data[sks_pkg::Q_W-1:0];
                    default:                 me_reg <= me_reg;
                endcase
            end

            if (fire_out)
            begin
                est_reg <= next_est_reg;
                err_reg <= err_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dir_reg <= smp_ge;
            mag_reg <= smp_ge ? (smp - est_reg) : (est_reg - smp);
        end

        if (state_reg == sks_pkg::S_DIV && div_rsp.done)
            gain_reg <= div_rsp.gain;

        if (state_reg == sks_pkg::S_M2)
        begin
            // the step equals |new - old| since the estimate never wraps
            step_reg     <= prod_hi;
            next_est_reg <= dir_reg ? (est_reg + prod_hi) : (est_reg - prod_hi);
        end

        if (state_reg == sks_pkg::S_M3)
            e1_reg <= prod_hi[sks_pkg::ERR_W-1:0];

        if (fire_out)
        begin
            out_sample_reg <= next_est_reg[sks_pkg::FRAC_W +: sks_pkg::SAMPLE_W];
            out_full_reg   <= next_est_reg;
        end
    end

`ifndef ASSERT_OFF
    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == sks_pkg::S_DIV)
        else $error("accepted request did not start the divider");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == sks_pkg::S_DIV)
        else $error("divider finished outside the divide state");

    a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_full_reg == est_reg)
        else $error("pending result differs from stored estimate");

    a_out_int_part: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_sample_reg == out_full_reg[sks_pkg::FRAC_W +: sks_pkg::SAMPLE_W])
        else $error("integer part does not match full estimate");
`endif

endmodule

@@ tb/scalar_kalman_smoother_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench for scalar_kalman_smoother: directed and random samples
// depends on sks_pkg, sks_if and the scalar_kalman_smoother rtl
module scalar_kalman_smoother_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_SEG  = 50;
    localparam int SEGS_PER_PHASE = 5;

    typedef struct packed {
        logic [sks_pkg::SAMPLE_W-1:0] whole;
        logic [sks_pkg::EST_W-1:0]    full;
    } filtered_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [sks_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sks_pkg::CFG_DATA_W-1:0] cfg_data;

    sks_in_if  sample_if ();
    sks_out_if result_if ();

    scalar_kalman_smoother u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (sample_if),
        .out_ch    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // filter state and register copies kept by the testbench
    logic [sks_pkg::EST_W-1:0] est_q;
    logic [sks_pkg::ERR_W-1:0] est_err;
    logic [sks_pkg::ME_W-1:0]  meas_err;
    logic [sks_pkg::Q_W-1:0]   proc_noise;

    filtered_t pending_estimates[$];
    filtered_t head_estimate;
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one kalman step on the local state; queues the estimate the block must return
    function automatic void kalman_update(input logic [sks_pkg::SAMPLE_W-1:0] smp_in);
        logic [63:0] smp, old, err, den, gain, mag, stepv, nxt, delta, e1, e2, enew;
        smp  = 64'(smp_in) << sks_pkg::FRAC_W;
        old  = 64'(est_q);
        err  = 64'(est_err);
        den  = err + 64'(meas_err);
        gain = 64'd0;
        if (den != 64'd0)
        begin
            gain = (err << sks_pkg::FRAC_W) / den;
            if (gain > ((64'd1 << sks_pkg::FRAC_W) - 64'd1))
                gain = (64'd1 << sks_pkg::FRAC_W) - 64'd1;
        end
        if (smp >= old)
        begin
            mag   = smp - old;
            stepv = (mag * gain) >> sks_pkg::FRAC_W;
            nxt   = old + stepv;
        end
        else
        begin
            mag   = old - smp;
            stepv = (mag * gain) >> sks_pkg::FRAC_W;
            nxt   = old - stepv;
        end
        nxt   = nxt & ((64'd1 << sks_pkg::EST_W) - 64'd1);
        delta = (nxt >= old) ? (nxt - old) : (old - nxt);
        e1    = (((64'd1 << sks_pkg::FRAC_W) - gain) * err) >> sks_pkg::FRAC_W;
        e2    = (delta * 64'(proc_noise)) >> sks_pkg::FRAC_W;
        enew  = e1 + e2;
        if (enew > 64'(sks_pkg::ERR_MAX))
            enew = 64'(sks_pkg::ERR_MAX);
        est_err = enew[sks_pkg::ERR_W-1:0];
        est_q   = nxt[sks_pkg::EST_W-1:0];
        pending_estimates.push_back('{nxt[sks_pkg::EST_W-1:sks_pkg::FRAC_W],
                                      nxt[sks_pkg::EST_W-1:0]});
    endfunction

    // receiver side: random back-pressure on results
    initial
    begin
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (result_if.valid && result_if.ready)
        begin
            if (pending_estimates.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, got %0d / %0d",
                         $time, result_if.filtered_sample, result_if.filtered_full);
            end
            else
            begin
                head_estimate = pending_estimates.pop_front();
                if (result_if.filtered_sample !== head_estimate.whole)
                begin
                    mismatch_count++;
                    $display("%0t: filtered_sample expected %0d, got %0d",
                             $time, head_estimate.whole, result_if.filtered_sample);
                end
                if (result_if.filtered_full !== head_estimate.full)
                begin
                    mismatch_count++;
                    $display("%0t: filtered_full expected 0x%07h, got 0x%07h",
                             $time, head_estimate.full, result_if.filtered_full);
                end
            end
        end
    end

    // watchdog on cycles where neither channel moves anything
    always @(posedge clk)
    begin
        if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, pending_estimates.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_sample(input logic [sks_pkg::SAMPLE_W-1:0] smp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_if.valid <= 1'b0;
            @(posedge clk);
        end
        sample_if.valid  <= 1'b1;
        sample_if.sample <= smp;
        do
            @(posedge clk);
        while (!sample_if.ready);
        kalman_update(smp);
    endtask

    // hold off requests until every outstanding result is back
    task automatic wait_idle();
        sample_if.valid <= 1'b0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(input logic [sks_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [sks_pkg::CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == sks_pkg::REG_MEAS_ERR)
            meas_err = data[sks_pkg::ME_W-1:0];
        else if (idx == sks_pkg::REG_PROC_NOISE)
            proc_noise = data[sks_pkg::Q_W-1:0];
    endtask

    task automatic test_reset_defaults();
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd2048);
    endtask

    // gain pins just below one, then the error decays to zero and the estimate freezes
    task automatic test_zero_meas_error();
        write_register(sks_pkg::REG_MEAS_ERR, '0);
        write_register(sks_pkg::REG_PROC_NOISE, '0);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd1000);
        send_sample(12'd0);
        send_sample(12'd3000);
    endtask

    task automatic test_error_saturation();
        write_register(sks_pkg::REG_MEAS_ERR, sks_pkg::CFG_DATA_W'(1));
        write_register(sks_pkg::REG_PROC_NOISE, sks_pkg::CFG_DATA_W'(16'hFFFF));
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd4095);
    endtask

    task automatic test_field_extremes();
        write_register(sks_pkg::REG_MEAS_ERR, {sks_pkg::CFG_DATA_W{1'b1}});
        write_register(sks_pkg::REG_PROC_NOISE, sks_pkg::CFG_DATA_W'(16'hFFFF));
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd1);
        send_sample(12'd2048);
        write_register(sks_pkg::REG_MEAS_ERR, sks_pkg::CFG_DATA_W'(sks_pkg::ME_RESET));
        write_register(sks_pkg::REG_PROC_NOISE, sks_pkg::CFG_DATA_W'(sks_pkg::Q_RESET));
    endtask

    // segments of noisy steady levels with jumps, each under a fresh register setting
    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int                        base;
        int                        level;
        logic [sks_pkg::ME_W-1:0]  me_val;
        logic [sks_pkg::Q_W-1:0]   q_val;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int seg = 0; seg < SEGS_PER_PHASE; seg++)
        begin
            case ($urandom_range(5))
                0: me_val = '0;
                1: me_val = sks_pkg::ME_W'(1);
                2: me_val = '1;
                3: me_val = sks_pkg::ME_W'($urandom_range(1, 262143));
                default: me_val = sks_pkg::ME_W'($urandom_range(1, 16777215));
            endcase
            case ($urandom_range(4))
                0: q_val = '0;
                1: q_val = '1;
                2: q_val = sks_pkg::Q_RESET;
                default: q_val = sks_pkg::Q_W'($urandom_range(65535));
            endcase
            write_register(sks_pkg::REG_MEAS_ERR, sks_pkg::CFG_DATA_W'(me_val));
            write_register(sks_pkg::REG_PROC_NOISE, sks_pkg::CFG_DATA_W'(q_val));
            base = $urandom_range(4095);
            for (int i = 0; i < ITEMS_PER_SEG; i++)
            begin
                case ($urandom_range(9)) inside
                    [0:4]: level = base + int'($urandom_range(64)) - 32;
                    [5:6]: level = $urandom_range(4095);
                    7:     level = 0;
                    8:     level = 4095;
                    default:
                    begin
                        base  = $urandom_range(4095);
                        level = base;
                    end
                endcase
                if (level < 0)
                    level = 0;
                if (level > 4095)
                    level = 4095;
                send_sample(level[sks_pkg::SAMPLE_W-1:0]);
            end
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        sample_if.valid <= 1'b0;
        sample_if.sample <= '0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        est_q      = '0;
        est_err    = sks_pkg::ERR_RESET;
        meas_err   = sks_pkg::ME_RESET;
        proc_noise = sks_pkg::Q_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_zero_meas_error();
        test_error_saturation();
        test_field_extremes();
        test_random_traffic(10, 78);
        test_random_traffic(78, 10);
        test_random_traffic(0, 0);

        wait_idle();
        repeat (30) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
